// ===== src/sbs_pkg.sv =====
package sbs_pkg;

   localparam int DEFAULT_PENDING_DEPTH = 32;

   localparam logic [7:0] CHAR_PERIOD   = 8'h2E;
   localparam logic [7:0] CHAR_BANG     = 8'h21;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;
   localparam logic [7:0] CHAR_SEMI     = 8'h3B;
   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_TAB      = 8'h09;
   localparam logic [7:0] CHAR_CR       = 8'h0D;
   localparam logic [7:0] CHAR_LF       = 8'h0A;
   localparam logic [7:0] CHAR_VT       = 8'h0B;
   localparam logic [7:0] CHAR_FF       = 8'h0C;

   localparam logic [1:0] CODE_SPACE = 2'd0;
   localparam logic [1:0] CODE_TAB   = 2'd1;
   localparam logic [1:0] CODE_CR    = 2'd2;
   localparam logic [1:0] CODE_LF    = 2'd3;

   typedef enum logic [1:0] {
      MODE_START    = 2'd0,
      MODE_SENTENCE = 2'd1,
      MODE_SKIP     = 2'd2
   } scan_mode_type;

   typedef enum logic [1:0] {
      SEL_HELD     = 2'd0,
      SEL_SPACE    = 2'd1,
      SEL_LINE_END = 2'd2
   } out_sel_type;

   typedef struct packed {
      logic        capture;
      logic        load;
      out_sel_type sel;
      logic        run_last;
      logic        flush_step;
   } sbs_cmd_type;

   typedef struct packed {
      logic out_free;
      logic plan_held;
      logic plan_flush;
      logic plan_line_end;
      logic job_flush;
      logic flush_one;
      logic job_line_end;
   } sbs_status_type;

   function automatic logic is_delim(input logic [7:0] b);
      return (b == CHAR_PERIOD) || (b == CHAR_BANG) || (b == CHAR_QUESTION) ||
             (b == CHAR_SEMI);
   endfunction

   function automatic logic is_trim_space(input logic [7:0] b);
      return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR) || (b == CHAR_LF);
   endfunction

   function automatic logic is_any_space(input logic [7:0] b);
      return is_trim_space(b) || (b == CHAR_VT) || (b == CHAR_FF);
   endfunction

   function automatic logic [1:0] space_code(input logic [7:0] b);
      logic [1:0] c;
      c = CODE_SPACE;
      if (b == CHAR_TAB) c = CODE_TAB;
      else if (b == CHAR_CR) c = CODE_CR;
      else if (b == CHAR_LF) c = CODE_LF;
      return c;
   endfunction

   function automatic logic [7:0] code_to_byte(input logic [1:0] c);
      logic [7:0] b;
      unique case (c)
         CODE_TAB: b = CHAR_TAB;
         CODE_CR:  b = CHAR_CR;
         CODE_LF:  b = CHAR_LF;
         default:  b = CHAR_SPACE;
      endcase
      return b;
   endfunction

endpackage

// ===== src/sbs_datapath.sv =====
module sbs_datapath #(
   parameter int PENDING_DEPTH = sbs_pkg::DEFAULT_PENDING_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_text_byte,
   input  logic                   req_line_end,
   input  sbs_pkg::sbs_cmd_type   cmd,
   output sbs_pkg::sbs_status_type status,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_sentence_end,
   output logic                   rsp_space_lost,
   output logic                   rsp_run_last
);

   localparam int CNT_W  = $clog2(PENDING_DEPTH + 1);
   localparam int ADDR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

   // scan state
   sbs_pkg::scan_mode_type mode_ff, mode_in;
   logic [7:0]             held_ff, held_in;
   logic                   hv_ff, hv_in;
   logic                   hd_ff, hd_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   ovf_ff, ovf_in;

   // pending whitespace store
   logic [1:0]             mem [PENDING_DEPTH];
   logic                   wr_en;
   logic [1:0]             rd_data_ff;

   // job registers for the item being emitted
   logic [7:0]             job_a_byte_ff;
   logic                   job_a_end_ff;
   logic [7:0]             job_c_byte_ff;
   logic                   job_c_ff;
   logic [CNT_W-1:0]       flush_left_ff, flush_left_in;
   logic                   job_lost_ff;
   logic [ADDR_W-1:0]      idx_ff, idx_in;

   // output register
   logic                   rsp_valid_ff;
   logic [7:0]             out_byte_ff;
   logic                   out_end_ff;
   logic                   out_lost_ff;
   logic                   out_last_ff;

   // plan for the offered item
   logic                   plan_a, plan_a_end, plan_flush, plan_c;
   logic [7:0]             b;

   assign b = req_text_byte;

   always_comb begin
      mode_in    = mode_ff;
      held_in    = held_ff;
      hv_in      = hv_ff;
      hd_in      = hd_ff;
      cnt_in     = cnt_ff;
      ovf_in     = ovf_ff;
      wr_en      = 1'b0;
      plan_a     = 1'b0;
      plan_a_end = 1'b0;
      plan_flush = 1'b0;
      plan_c     = 1'b0;
      unique case (mode_ff)
         sbs_pkg::MODE_SENTENCE: begin
            if (hv_ff && hd_ff && sbs_pkg::is_any_space(b)) begin
               plan_a     = 1'b1;
               plan_a_end = 1'b1;
               hv_in      = 1'b0;
               hd_in      = 1'b0;
               cnt_in     = '0;
               ovf_in     = 1'b0;
               mode_in    = sbs_pkg::MODE_SKIP;
            end else if (sbs_pkg::is_trim_space(b)) begin
               if (cnt_ff < CNT_W'(PENDING_DEPTH)) begin
                  wr_en  = 1'b1;
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end else begin
               plan_a     = hv_ff;
               plan_flush = (cnt_ff != '0);
               cnt_in     = '0;
               ovf_in     = 1'b0;
               held_in    = b;
               hv_in      = 1'b1;
               hd_in      = sbs_pkg::is_delim(b);
               mode_in    = sbs_pkg::MODE_SENTENCE;
            end
         end
         sbs_pkg::MODE_SKIP: begin
            if (!sbs_pkg::is_any_space(b)) begin
               held_in = b;
               hv_in   = 1'b1;
               hd_in   = sbs_pkg::is_delim(b);
               mode_in = sbs_pkg::MODE_SENTENCE;
            end
         end
         default: begin
            if (!sbs_pkg::is_trim_space(b)) begin
               held_in = b;
               hv_in   = 1'b1;
               hd_in   = sbs_pkg::is_delim(b);
               mode_in = sbs_pkg::MODE_SENTENCE;
            end else begin
               mode_in = sbs_pkg::MODE_START;
            end
         end
      endcase
      plan_c = req_line_end && hv_in;
   end

   always_comb begin
      flush_left_in = flush_left_ff;
      idx_in        = idx_ff;
      if (cmd.capture) begin
         flush_left_in = plan_flush ? cnt_ff : '0;
         idx_in        = '0;
      end else if (cmd.flush_step) begin
         flush_left_in = flush_left_ff - CNT_W'(1);
         idx_in        = idx_ff + ADDR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= sbs_pkg::MODE_START;
         held_ff <= '0;
         hv_ff   <= 1'b0;
         hd_ff   <= 1'b0;
         cnt_ff  <= '0;
         ovf_ff  <= 1'b0;
      end else if (cmd.capture) begin
         if (req_line_end) begin
            mode_ff <= sbs_pkg::MODE_START;
            held_ff <= '0;
            hv_ff   <= 1'b0;
            hd_ff   <= 1'b0;
            cnt_ff  <= '0;
            ovf_ff  <= 1'b0;
         end else begin
            mode_ff <= mode_in;
            held_ff <= held_in;
            hv_ff   <= hv_in;
            hd_ff   <= hd_in;
            cnt_ff  <= cnt_in;
            ovf_ff  <= ovf_in;
         end
      end
   end

   // read address follows the next flush index so the data is ready on time
   always_ff @(posedge clock) begin
      if (cmd.capture && wr_en) begin
         mem[cnt_ff[ADDR_W-1:0]] <= sbs_pkg::space_code(b);
      end
      rd_data_ff <= mem[idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_c_ff      <= 1'b0;
         flush_left_ff <= '0;
         idx_ff        <= '0;
      end else begin
         flush_left_ff <= flush_left_in;
         idx_ff        <= idx_in;
         if (cmd.capture) begin
            job_c_ff <= plan_c;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         job_a_byte_ff <= held_ff;
         job_a_end_ff  <= plan_a_end;
         job_c_byte_ff <= held_in;
         job_lost_ff   <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_last_ff <= cmd.run_last;
         case (cmd.sel)
            sbs_pkg::SEL_SPACE: begin
               out_byte_ff <= sbs_pkg::code_to_byte(rd_data_ff);
               out_end_ff  <= 1'b0;
               out_lost_ff <= job_lost_ff && (flush_left_ff == CNT_W'(1));
            end
            sbs_pkg::SEL_LINE_END: begin
               out_byte_ff <= job_c_byte_ff;
               out_end_ff  <= 1'b1;
               out_lost_ff <= 1'b0;
            end
            default: begin
               out_byte_ff <= job_a_byte_ff;
               out_end_ff  <= job_a_end_ff;
               out_lost_ff <= 1'b0;
            end
         endcase
      end
   end

   assign status.out_free      = !rsp_valid_ff || !rsp_stall;
   assign status.plan_held     = plan_a;
   assign status.plan_flush    = plan_flush;
   assign status.plan_line_end = plan_c;
   assign status.job_flush     = (flush_left_ff != '0);
   assign status.flush_one     = (flush_left_ff == CNT_W'(1));
   assign status.job_line_end  = job_c_ff;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_sentence_end = out_end_ff;
   assign rsp_space_lost   = out_lost_ff;
   assign rsp_run_last     = out_last_ff;

endmodule

// ===== src/sbs_controller.sv =====
module sbs_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sbs_pkg::sbs_status_type status,
   output sbs_pkg::sbs_cmd_type   cmd
);

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_HELD     = 4'b0010,
      ST_FLUSH    = 4'b0100,
      ST_LINE_END = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in       = state_ff;
      cmd.capture    = 1'b0;
      cmd.load       = 1'b0;
      cmd.sel        = sbs_pkg::SEL_HELD;
      cmd.run_last   = 1'b0;
      cmd.flush_step = 1'b0;
      req_stall      = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (status.plan_held) state_in = ST_HELD;
               else if (status.plan_flush) state_in = ST_FLUSH;
               else if (status.plan_line_end) state_in = ST_LINE_END;
            end
         end
         ST_HELD: begin
            if (status.out_free) begin
               cmd.load     = 1'b1;
               cmd.sel      = sbs_pkg::SEL_HELD;
               cmd.run_last = !status.job_flush && !status.job_line_end;
               if (status.job_flush) state_in = ST_FLUSH;
               else if (status.job_line_end) state_in = ST_LINE_END;
               else state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.load       = 1'b1;
               cmd.sel        = sbs_pkg::SEL_SPACE;
               cmd.flush_step = 1'b1;
               cmd.run_last   = status.flush_one && !status.job_line_end;
               if (status.flush_one) begin
                  state_in = status.job_line_end ? ST_LINE_END : ST_IDLE;
               end
            end
         end
         ST_LINE_END: begin
            if (status.out_free) begin
               cmd.load     = 1'b1;
               cmd.sel      = sbs_pkg::SEL_LINE_END;
               cmd.run_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/sentence_boundary_splitter_unit.sv =====
// Sentence boundary splitter: takes a line one byte per item (req_line_end on
// the last byte) and returns the kept bytes of each trimmed sentence, with
// rsp_sentence_end on the last byte of each sentence and rsp_run_last on the
// last result caused by an input byte. A byte is taken when the block is idle;
// its n results (0 to PENDING_DEPTH + 2) then leave at one per cycle unless the
// output stalls, through a single output register, and the next byte waits for
// the last of them. Held-back whitespace is replayed, one entry a cycle unless
// stalled, from a PENDING_DEPTH-entry store with one registered read port.
module sentence_boundary_splitter_unit #(
   parameter int PENDING_DEPTH = sbs_pkg::DEFAULT_PENDING_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_line_end,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_sentence_end,
   output logic       rsp_space_lost,
   output logic       rsp_run_last
);

   sbs_pkg::sbs_cmd_type    cmd;
   sbs_pkg::sbs_status_type status;

   sbs_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sbs_datapath #(
      .PENDING_DEPTH (PENDING_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_text_byte    (req_text_byte),
      .req_line_end     (req_line_end),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_sentence_end (rsp_sentence_end),
      .rsp_space_lost   (rsp_space_lost),
      .rsp_run_last     (rsp_run_last)
   );

endmodule
